FILE: rtl/lvnf_pkg.sv
package lvnf_pkg;

    localparam int PIXEL_BITS = 16;
    localparam int WORD_W     = PIXEL_BITS + 1;
    localparam int MAX_X_DEF  = 256;
    localparam int MAX_Y_DEF  = 256;

    localparam int SIZE_XY_W  = 9;
    localparam int SIZE_Z_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [SIZE_XY_W-1:0]  SIZE_X_RST = SIZE_XY_W'(256);
    localparam logic [SIZE_XY_W-1:0]  SIZE_Y_RST = SIZE_XY_W'(256);
    localparam logic [SIZE_Z_W-1:0]   SIZE_Z_RST = SIZE_Z_W'(256);
    localparam logic [PIXEL_BITS-1:0] CUTOFF_RST = PIXEL_BITS'(100);

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF = 2'd3;

    localparam logic REQ_VOXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    // Rounded mean of six: floor((sum + 3) * DIV6_MULT / 2^DIV6_SHIFT), exact below 2^19.
    localparam int SUM_W      = PIXEL_BITS + 3;
    localparam int DIV6_SHIFT = 21;
    localparam logic [SUM_W-1:0] DIV6_MULT = SUM_W'(349526);
    localparam logic [SUM_W-1:0] ROUND_ADD = SUM_W'(3);

    typedef struct packed {
        logic                  req_type;
        logic [PIXEL_BITS-1:0] voxel_in;
        logic                  mask_in;
    } item_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] voxel_out;
        logic                  was_replaced;
        logic                  last_voxel;
    } result_t;

    typedef struct packed {
        logic              emit;
        logic [WORD_W-1:0] word;
    } qword_t;

    typedef struct packed {
        logic       full;
        logic       empty;
        logic [1:0] count;
    } qstat_t;

endpackage

FILE: rtl/low_voxel_neighbor_fill.sv
// A voxel's result is formed once the voxel one plane further on is taken (or the drain word
// that stands for it), then passes the sum and output registers; the last plane leaves on
// drain words. Throughput: one word per cycle while the receiver does not stall; the
// two-plane window is four delay lines, each a memory with one write and one read per cycle.
// Reset: asynchronous, active low; sizes 256 x 256 x 256, cutoff 100, all positions at zero.
module low_voxel_neighbor_fill
    import lvnf_pkg::*;
#(
    parameter int MAX_X = MAX_X_DEF,
    parameter int MAX_Y = MAX_Y_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Widths that hold the clamped row length, plane height and plane area.
    localparam int XW = $clog2(MAX_X + 1);
    localparam int YW = $clog2(MAX_Y + 1);
    localparam int PW = $clog2(MAX_X * MAX_Y + 1);

    logic [SIZE_XY_W-1:0]  size_x_reg;
    logic [SIZE_XY_W-1:0]  size_y_reg;
    logic [SIZE_Z_W-1:0]   size_z_reg;
    logic [PIXEL_BITS-1:0] cutoff_reg;
    logic [PW-1:0]         plane_reg;

    logic [XW-1:0]       sx;
    logic [YW-1:0]       sy;
    logic [SIZE_Z_W-1:0] sz;
    logic                cfg_wr;
    logic                clear;

    qstat_t qstat;
    qword_t push_data;
    qword_t pop_data;
    logic   push;
    logic   pop;

    // The configuration port never holds off a write.
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // Any write to a size register abandons the volume in progress.
    assign clear = cfg_wr && (cfg_index != REG_CUTOFF);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= SIZE_X_RST;
            size_y_reg <= SIZE_Y_RST;
            size_z_reg <= SIZE_Z_RST;
            cutoff_reg <= CUTOFF_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                REG_SIZE_X: size_x_reg <= cfg_data[SIZE_XY_W-1:0];
                REG_SIZE_Y: size_y_reg <= cfg_data[SIZE_XY_W-1:0];
                REG_SIZE_Z: size_z_reg <= cfg_data[SIZE_Z_W-1:0];
                REG_CUTOFF: cutoff_reg <= cfg_data[PIXEL_BITS-1:0];
                default:    cutoff_reg <= cutoff_reg;
            endcase
        end
    end

    // Sizes in use: zero counts as one, and rows and planes are capped at the buffer limits.
    always_comb
    begin
        if (size_x_reg == '0)
        begin
            sx = XW'(1);
        end
        else if (32'(size_x_reg) > 32'(MAX_X))
        begin
            sx = XW'(MAX_X);
        end
        else
        begin
            sx = XW'(size_x_reg);
        end

        if (size_y_reg == '0)
        begin
            sy = YW'(1);
        end
        else if (32'(size_y_reg) > 32'(MAX_Y))
        begin
            sy = YW'(MAX_Y);
        end
        else
        begin
            sy = YW'(size_y_reg);
        end

        sz = (size_z_reg == '0) ? SIZE_Z_W'(1) : size_z_reg;
    end

    // The plane area is only needed by the window, which sees a word only after the queue has
    // registered it, so a registered product is always current.
    always_ff @(posedge clk)
    begin
        plane_reg <= PW'((XW + YW)'(sx) * (XW + YW)'(sy));
    end

    lvnf_front #(.XW(XW), .YW(YW)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (clear),
        .size_x     (sx),
        .size_y     (sy),
        .size_z     (sz),
        .item_valid (item_valid),
        .item       (item),
        .item_stall (item_stall),
        .qstat      (qstat),
        .push       (push),
        .push_data  (push_data)
    );

    lvnf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (qstat)
    );

    lvnf_back #(
        .MAX_X (MAX_X),
        .MAX_Y (MAX_Y),
        .XW    (XW),
        .YW    (YW),
        .PW    (PW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .clear        (clear),
        .size_x       (sx),
        .size_y       (sy),
        .size_z       (sz),
        .plane        (plane_reg),
        .cutoff       (cutoff_reg),
        .qstat        (qstat),
        .pop_data     (pop_data),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && qstat.full))
        else $error("front pushed a word into a full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.count != 2'd3)
        else $error("queue count beyond its depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("back popped an empty queue");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop && qstat.empty) |=> (qstat.count == 2'd1))
        else $error("queue lost a pushed word");
`endif

endmodule

FILE: rtl/lvnf_delay.sv
module lvnf_delay
    import lvnf_pkg::*;
#(
    parameter int DEPTH = 2,
    parameter int LW    = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear,
    input  logic              shift,
    input  logic [LW-1:0]     len,
    input  logic [WORD_W-1:0] d,
    output logic [WORD_W-1:0] q
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = (LW > AW) ? LW : AW;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [AW-1:0]     ptr_reg;
    logic [AW-1:0]     ptr_next;
    logic [WORD_W-1:0] q_reg;
    logic              wrap;

    // A length of zero means the tap is the word shifted in with it.
    assign wrap = (CW'(ptr_reg) >= (CW'(len) - CW'(1)));

    always_comb
    begin
        ptr_next = ptr_reg;
        if (clear)
        begin
            ptr_next = '0;
        end
        else if (shift)
        begin
            ptr_next = wrap ? '0 : ptr_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else
        begin
            ptr_reg <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            mem[ptr_reg] <= d;
            q_reg        <= (len == '0) ? d : mem[ptr_reg];
        end
    end

    assign q = q_reg;

endmodule

FILE: rtl/lvnf_queue.sv
module lvnf_queue
    import lvnf_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  qword_t push_data,
    input  logic   pop,
    output qword_t pop_data,
    output qstat_t stat
);

    qword_t     ent_reg [2];
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data   = ent_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign stat.count = count_reg;

endmodule

FILE: rtl/lvnf_front.sv
module lvnf_front
    import lvnf_pkg::*;
#(
    parameter int XW = 9,
    parameter int YW = 9
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  logic [XW-1:0]       size_x,
    input  logic [YW-1:0]       size_y,
    input  logic [SIZE_Z_W-1:0] size_z,
    input  logic                item_valid,
    input  item_t               item,
    output logic                item_stall,
    input  qstat_t              qstat,
    output logic                push,
    output qword_t              push_data
);

    logic [XW-1:0]       ix_reg, ix_next;
    logic [YW-1:0]       iy_reg, iy_next;
    logic [SIZE_Z_W-1:0] iz_reg, iz_next;
    logic                accept;
    logic                is_voxel;
    logic                full;
    logic                row_end;
    logic                plane_end;

    assign item_stall = qstat.full;
    assign accept     = item_valid && !qstat.full;
    assign is_voxel   = (item.req_type == REQ_VOXEL);
    assign full       = (iz_reg == size_z);
    assign row_end    = (ix_reg == size_x - XW'(1));
    assign plane_end  = row_end && (iy_reg == size_y - YW'(1));

    // Voxels enter until the volume is in; drain ticks count out the last plane.
    assign push = accept && (is_voxel ? !full : full);

    assign push_data.emit = is_voxel ? (iz_reg != '0) : 1'b1;
    assign push_data.word = is_voxel ? {item.mask_in, item.voxel_in} : '0;

    always_comb
    begin
        ix_next = ix_reg;
        iy_next = iy_reg;
        iz_next = iz_reg;
        if (clear)
        begin
            ix_next = '0;
            iy_next = '0;
            iz_next = '0;
        end
        else if (push)
        begin
            ix_next = row_end ? '0 : ix_reg + XW'(1);
            if (row_end)
            begin
                iy_next = plane_end ? '0 : iy_reg + YW'(1);
            end
            if (plane_end)
            begin
                iz_next = is_voxel ? iz_reg + SIZE_Z_W'(1) : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ix_reg <= '0;
            iy_reg <= '0;
            iz_reg <= '0;
        end
        else
        begin
            ix_reg <= ix_next;
            iy_reg <= iy_next;
            iz_reg <= iz_next;
        end
    end

endmodule

FILE: rtl/lvnf_back.sv
module lvnf_back
    import lvnf_pkg::*;
#(
    parameter int MAX_X = 256,
    parameter int MAX_Y = 256,
    parameter int XW    = 9,
    parameter int YW    = 9,
    parameter int PW    = 17
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  clear,
    input  logic [XW-1:0]         size_x,
    input  logic [YW-1:0]         size_y,
    input  logic [SIZE_Z_W-1:0]   size_z,
    input  logic [PW-1:0]         plane,
    input  logic [PIXEL_BITS-1:0] cutoff,
    input  qstat_t                qstat,
    input  qword_t                pop_data,
    output logic                  pop,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result
);

    localparam int XY_DEPTH = MAX_X * MAX_Y;

    logic [PW-1:0]      len_plane;
    logic [PW-1:0]      len_yp;
    logic [XW-1:0]      len_ym;
    logic [WORD_W-1:0]  xp, yp, ym, zm;
    logic [WORD_W-1:0]  zp_reg, c_reg, xm_reg;
    logic               t_valid_reg, t_valid_next;
    logic               s_valid_reg, s_valid_next;
    logic               o_valid_reg, o_valid_next;
    logic               o_free, s_move, s_free, t_move, t_free;

    logic [XW-1:0]       ox_reg, ox_next;
    logic [YW-1:0]       oy_reg, oy_next;
    logic [SIZE_Z_W-1:0] oz_reg, oz_next;

    logic [PIXEL_BITS-1:0] cv;
    logic                  x_lo, x_hi, y_lo, y_hi, z_lo, z_hi, last;
    logic [SUM_W-1:0]      sum;

    logic [SUM_W-1:0]      s_sum_reg;
    logic                  s_repl_reg;
    logic [PIXEL_BITS-1:0] s_cv_reg;
    logic                  s_last_reg;
    logic [2*SUM_W-1:0]    prod;
    result_t               out_reg;

    assign o_free = !o_valid_reg || !result_stall;
    assign s_move = s_valid_reg && o_free;
    assign s_free = !s_valid_reg || s_move;
    assign t_move = t_valid_reg && s_free;
    assign t_free = !t_valid_reg || t_move;
    assign pop    = !qstat.empty && t_free;

    assign len_plane = plane - PW'(1);
    assign len_yp    = plane - PW'(size_x);
    assign len_ym    = size_x - XW'(1);

    lvnf_delay #(.DEPTH(XY_DEPTH), .LW(PW)) u_xp (
        .clk(clk), .rst_n(rst_n), .clear(clear), .shift(pop),
        .len(len_plane), .d(pop_data.word), .q(xp)
    );

    lvnf_delay #(.DEPTH(XY_DEPTH), .LW(PW)) u_yp (
        .clk(clk), .rst_n(rst_n), .clear(clear), .shift(pop),
        .len(len_yp), .d(pop_data.word), .q(yp)
    );

    lvnf_delay #(.DEPTH(MAX_X), .LW(XW)) u_ym (
        .clk(clk), .rst_n(rst_n), .clear(clear), .shift(pop),
        .len(len_ym), .d(c_reg), .q(ym)
    );

    lvnf_delay #(.DEPTH(XY_DEPTH), .LW(PW)) u_zm (
        .clk(clk), .rst_n(rst_n), .clear(clear), .shift(pop),
        .len(len_plane), .d(c_reg), .q(zm)
    );

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            zp_reg <= pop_data.word;
            c_reg  <= xp;
            xm_reg <= c_reg;
        end
    end

    assign cv   = c_reg[PIXEL_BITS-1:0];
    assign x_lo = (ox_reg != '0);
    assign x_hi = (ox_reg != size_x - XW'(1));
    assign y_lo = (oy_reg != '0);
    assign y_hi = (oy_reg != size_y - YW'(1));
    assign z_lo = (oz_reg != '0);
    assign z_hi = (oz_reg != size_z - SIZE_Z_W'(1));
    assign last = !x_hi && !y_hi && !z_hi;

    // Neighbours outside the volume take the centre value.
    assign sum = SUM_W'(x_lo ? xm_reg[PIXEL_BITS-1:0] : cv)
               + SUM_W'(x_hi ? xp[PIXEL_BITS-1:0]     : cv)
               + SUM_W'(y_lo ? ym[PIXEL_BITS-1:0]     : cv)
               + SUM_W'(y_hi ? yp[PIXEL_BITS-1:0]     : cv)
               + SUM_W'(z_lo ? zm[PIXEL_BITS-1:0]     : cv)
               + SUM_W'(z_hi ? zp_reg[PIXEL_BITS-1:0] : cv)
               + ROUND_ADD;

    always_comb
    begin
        ox_next = ox_reg;
        oy_next = oy_reg;
        oz_next = oz_reg;
        if (clear)
        begin
            ox_next = '0;
            oy_next = '0;
            oz_next = '0;
        end
        else if (t_move)
        begin
            ox_next = x_hi ? ox_reg + XW'(1) : '0;
            if (!x_hi)
            begin
                oy_next = y_hi ? oy_reg + YW'(1) : '0;
                if (!y_hi)
                begin
                    oz_next = z_hi ? oz_reg + SIZE_Z_W'(1) : '0;
                end
            end
        end
    end

    always_comb
    begin
        t_valid_next = t_move ? 1'b0 : t_valid_reg;
        if (pop)
        begin
            t_valid_next = pop_data.emit;
        end
        s_valid_next = t_move ? 1'b1 : (s_move ? 1'b0 : s_valid_reg);
        o_valid_next = s_move ? 1'b1 : (o_free ? 1'b0 : o_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            ox_reg      <= '0;
            oy_reg      <= '0;
            oz_reg      <= '0;
        end
        else
        begin
            t_valid_reg <= t_valid_next;
            s_valid_reg <= s_valid_next;
            o_valid_reg <= o_valid_next;
            ox_reg      <= ox_next;
            oy_reg      <= oy_next;
            oz_reg      <= oz_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (t_move)
        begin
            s_sum_reg  <= sum;
            s_repl_reg <= c_reg[PIXEL_BITS] && (cv < cutoff);
            s_cv_reg   <= cv;
            s_last_reg <= last;
        end
    end

    assign prod = (2*SUM_W)'(s_sum_reg) * (2*SUM_W)'(DIV6_MULT);

    always_ff @(posedge clk)
    begin
        if (s_move)
        begin
            out_reg.voxel_out    <= s_repl_reg ? prod[DIV6_SHIFT +: PIXEL_BITS] : s_cv_reg;
            out_reg.was_replaced <= s_repl_reg;
            out_reg.last_voxel   <= s_last_reg;
        end
    end

    assign result_valid = o_valid_reg;
    assign result       = out_reg;

endmodule

FILE: bench/low_voxel_neighbor_fill_test.sv
module low_voxel_neighbor_fill_test;
    import lvnf_pkg::*;

    // The block keeps two planes of 256 x 256 voxels; our own copy of that window has the
    // same depth so that ring addressing matches for every legal size.
    localparam int WIN_DEPTH  = 2 * MAX_X_DEF * MAX_Y_DEF;
    localparam int DONE_WAIT  = 12;   // settle time for results still inside the block
    localparam int WDOG_LIMIT = 5000; // cycles with nothing accepted on any channel

    logic                  clk;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_stall;
    item_t                 item;
    logic                  result_valid;
    logic                  result_stall;
    result_t               result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    low_voxel_neighbor_fill i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Our own view of the block: the plane window, both stream positions and the registers
    // as written (the widths are masked, the clamping is done where the sizes are used).
    logic [WORD_W-1:0] shadow_window [WIN_DEPTH];
    longint            in_pos;
    longint            out_pos;
    longint            reg_size_x;
    longint            reg_size_y;
    longint            reg_size_z;
    longint            reg_cutoff;

    result_t           pending_results [$];

    // Idling percentages for both sides, and the counted hold-off of the receiver.
    int                send_idle_pct;
    int                recv_stall_pct;
    int                recv_hold;

    int                mismatches;
    int                words_sent;
    int                results_seen;
    int                replaced_seen;
    int                volumes_done;
    int                quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Sizes as the block uses them: rows and planes clamped to the window, zero planes as one.
    function automatic longint used_x();
        return (reg_size_x < 1) ? 1 : ((reg_size_x > MAX_X_DEF) ? MAX_X_DEF : reg_size_x);
    endfunction

    function automatic longint used_y();
        return (reg_size_y < 1) ? 1 : ((reg_size_y > MAX_Y_DEF) ? MAX_Y_DEF : reg_size_y);
    endfunction

    function automatic longint used_z();
        return (reg_size_z < 1) ? 1 : reg_size_z;
    endfunction

    // A stored word at a stream position; the voxel arriving in this word is not yet in the
    // window, so it is taken from the word itself.
    function automatic logic [WORD_W-1:0] window_word(longint pos, bit have_cur, longint cur_pos,
                                                     logic [WORD_W-1:0] cur_word);
        longint ring;
        ring = 2 * used_x() * used_y();
        if (have_cur && pos == cur_pos)
            return cur_word;
        return shadow_window[(pos % ring) % WIN_DEPTH];
    endfunction

    // The intensity part of a stored word.
    function automatic longint window_pix(longint pos, bit have_cur, longint cur_pos,
                                          logic [WORD_W-1:0] cur_word);
        logic [WORD_W-1:0] w;
        w = window_word(pos, have_cur, cur_pos, cur_word);
        return longint'(w[PIXEL_BITS-1:0]);
    endfunction

    // Works out the result for the voxel at the output position: the six-neighbour mean when
    // it is inside the mask and below the cutoff, otherwise the voxel as it came.
    function automatic result_t fill_voxel(bit have_cur, longint cur_pos,
                                           logic [WORD_W-1:0] cur_word);
        longint            sx;
        longint            sy;
        longint            sz;
        longint            plane;
        longint            o;
        longint            x;
        longint            y;
        longint            z;
        longint            sum;
        logic [WORD_W-1:0] centre;
        longint            cv;
        bit                repl;
        result_t           r;
        sx     = used_x();
        sy     = used_y();
        sz     = used_z();
        plane  = sx * sy;
        o      = out_pos;
        x      = o % sx;
        y      = (o / sx) % sy;
        z      = o / plane;
        centre = window_word(o, have_cur, cur_pos, cur_word);
        cv     = centre[PIXEL_BITS-1:0];
        // Neighbours beyond the volume's faces are replaced by the voxel itself.
        sum = 0;
        sum += (x > 0) ? window_pix(o - 1, have_cur, cur_pos, cur_word) : cv;
        sum += (x + 1 < sx) ? window_pix(o + 1, have_cur, cur_pos, cur_word) : cv;
        sum += (y > 0) ? window_pix(o - sx, have_cur, cur_pos, cur_word) : cv;
        sum += (y + 1 < sy) ? window_pix(o + sx, have_cur, cur_pos, cur_word) : cv;
        sum += (z > 0) ? window_pix(o - plane, have_cur, cur_pos, cur_word) : cv;
        sum += (z + 1 < sz) ? window_pix(o + plane, have_cur, cur_pos, cur_word) : cv;
        repl           = centre[PIXEL_BITS] && (cv < reg_cutoff);
        r.voxel_out    = repl ? PIXEL_BITS'((sum + 3) / 6) : PIXEL_BITS'(cv);
        r.was_replaced = repl;
        r.last_voxel   = (o + 1 == plane * sz);
        out_pos        = o + 1;
        return r;
    endfunction

    // Advances our copy of the block by one accepted word and queues any result it causes.
    function automatic void track_word(item_t w);
        longint            plane;
        longint            total;
        logic [WORD_W-1:0] packed_word;
        plane = used_x() * used_y();
        total = plane * used_z();
        if (w.req_type == REQ_VOXEL)
        begin
            // Once the whole volume is in, further voxels are dropped until it is drained.
            if (in_pos >= total)
                return;
            packed_word = {w.mask_in, w.voxel_in};
            if (in_pos >= plane)
                pending_results.push_back(fill_voxel(1'b1, in_pos, packed_word));
            shadow_window[(in_pos % (2 * plane)) % WIN_DEPTH] = packed_word;
            in_pos++;
        end
        else
        begin
            // A drain word only counts once the volume is complete and something is left.
            if (in_pos != total || out_pos >= total)
                return;
            pending_results.push_back(fill_voxel(1'b0, 0, '0));
            if (out_pos >= total)
            begin
                in_pos  = 0;
                out_pos = 0;
            end
        end
    endfunction

    // Offers one word, with random idle cycles before it, and holds it until it is taken.
    // Valid is left high after acceptance; the next call either replaces the word or idles.
    task automatic send_word(logic req, logic [PIXEL_BITS-1:0] value, logic mask);
        item_t w;
        w.req_type = req;
        w.voxel_in = value;
        w.mask_in  = mask;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        do
        begin
            @(posedge clk);
        end
        while (item_stall);
        track_word(w);
        words_sent++;
    endtask

    // Waits for every queued result, then for the block to settle behind words that cause none.
    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DONE_WAIT) @(posedge clk);
    endtask

    // Register writes only happen with the block idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (index)
            REG_SIZE_X: reg_size_x = value & 16'h01ff;
            REG_SIZE_Y: reg_size_y = value & 16'h01ff;
            REG_SIZE_Z: reg_size_z = value;
            default:    reg_cutoff = value;
        endcase
        // A size change starts a new volume; a cutoff change leaves the volume running.
        if (index != REG_CUTOFF)
        begin
            in_pos  = 0;
            out_pos = 0;
        end
    endtask

    task automatic set_volume(int sx, int sy, int sz, int cutoff);
        write_reg(REG_SIZE_X, CFG_DATA_W'(sx));
        write_reg(REG_SIZE_Y, CFG_DATA_W'(sy));
        write_reg(REG_SIZE_Z, CFG_DATA_W'(sz));
        write_reg(REG_CUTOFF, CFG_DATA_W'(cutoff));
    endtask

    // A random voxel: half the time near the cutoff so that both sides of it are common.
    function automatic logic [PIXEL_BITS-1:0] pick_voxel();
        longint lo;
        longint hi;
        if ($urandom_range(1))
            return PIXEL_BITS'($urandom);
        lo = (reg_cutoff > 8) ? reg_cutoff - 8 : 0;
        hi = (reg_cutoff < 65527) ? reg_cutoff + 8 : 65535;
        return PIXEL_BITS'($urandom_range(32'(hi), 32'(lo)));
    endfunction

    // One complete volume followed by its drain words; with noise, stray drain words come
    // early and stray voxels arrive after the volume is full.
    task automatic send_volume(bit noisy);
        longint total;
        longint plane;
        plane = used_x() * used_y();
        total = plane * used_z();
        for (longint n = 0; n < total; n++)
        begin
            if (noisy && $urandom_range(19) == 0)
                send_word(REQ_DRAIN, PIXEL_BITS'($urandom), 1'($urandom));
            send_word(REQ_VOXEL, pick_voxel(), 1'($urandom));
        end
        if (noisy && $urandom_range(1))
            send_word(REQ_VOXEL, PIXEL_BITS'($urandom), 1'($urandom));
        for (longint n = 0; n < plane; n++)
            send_word(REQ_DRAIN, PIXEL_BITS'($urandom), 1'($urandom));
        if (noisy && $urandom_range(1))
            send_word(REQ_DRAIN, PIXEL_BITS'($urandom), 1'($urandom));
        volumes_done++;
    endtask

    // Hand-picked volume: extreme values around the cutoff, early and surplus drains, a
    // voxel while the volume is full, then a single-voxel volume from sizes written as zero.
    task automatic test_directed();
        logic [PIXEL_BITS-1:0] vals [12];
        logic                  masks [12];
        vals  = '{16'h0000, 16'hffff, 16'hffff, 16'h0001, 16'h7fff, 16'hffff,
                  16'h0000, 16'hffff, 16'h000c, 16'h8000, 16'h7fff, 16'h0003};
        masks = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
        set_volume(3, 2, 2, 16'h8000);
        send_word(REQ_DRAIN, 16'h1234, 1'b1);
        foreach (vals[k])
            send_word(REQ_VOXEL, vals[k], masks[k]);
        send_word(REQ_VOXEL, 16'h0000, 1'b1);
        repeat (6) send_word(REQ_DRAIN, 16'hffff, 1'b0);
        send_word(REQ_DRAIN, 16'h0000, 1'b1);
        set_volume(0, 0, 0, 16'hffff);
        send_word(REQ_VOXEL, 16'h0005, 1'b1);
        send_word(REQ_DRAIN, 16'h0000, 1'b0);
        send_word(REQ_VOXEL, 16'hfffe, 1'b1);
        send_word(REQ_DRAIN, 16'h0000, 1'b0);
    endtask

    // Widest rows allowed (an oversized row count is clamped) with no replacement at cutoff
    // zero, then a shorter row at the top cutoff after an oversized row count per plane, then
    // a deep volume abandoned part-way by a size write, and a small noisy volume.
    task automatic test_size_extremes();
        set_volume(16'hffff, 1, 1, 0);
        send_volume(1'b0);
        write_reg(REG_CUTOFF, 16'hffff);
        write_reg(REG_SIZE_Y, 16'h01ff);
        write_reg(REG_SIZE_Y, 16'd1);
        write_reg(REG_SIZE_X, 16'd48);
        send_volume(1'b0);
        set_volume(1, 1, 16'hffff, 16'h8000);
        repeat (20) send_word(REQ_VOXEL, pick_voxel(), 1'($urandom));
        write_reg(REG_SIZE_X, 16'd2);
        set_volume(2, 2, 2, 40000);
        send_volume(1'b1);
    endtask

    // Small random volumes, mostly clean, some with stray words, until the word budget is met.
    task automatic test_random_volumes(int budget);
        int start;
        start = words_sent;
        while (words_sent - start < budget)
        begin
            set_volume($urandom_range(6, 1), $urandom_range(5, 1), $urandom_range(4, 1),
                       $urandom);
            send_volume($urandom_range(3) == 0);
        end
    endtask

    // The receiver holds off long enough for the block to back up and stall its input, then
    // the sender waits for every result before carrying on.
    task automatic test_backpressure();
        set_volume(5, 4, 3, 30000);
        recv_hold = 300;
        send_volume(1'b0);
        wait_drained();
        send_volume(1'b1);
    endtask

    // Receiver stall, redrawn each cycle, or held for a counted stretch.
    always @(posedge clk)
    begin
        if (recv_hold > 0)
        begin
            result_stall <= 1'b1;
            recv_hold    <= recv_hold - 1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result voxel=%0d replaced=%0b last=%0b", $realtime,
                         result.voxel_out, result.was_replaced, result.last_voxel);
            end
            else
            begin
                result_t want;
                want = pending_results.pop_front();
                if (want.was_replaced)
                    replaced_seen++;
                if (result.voxel_out !== want.voxel_out)
                begin
                    mismatches++;
                    $display("%0t: voxel_out expected %0d actual %0d", $realtime,
                             want.voxel_out, result.voxel_out);
                end
                if (result.was_replaced !== want.was_replaced)
                begin
                    mismatches++;
                    $display("%0t: was_replaced expected %0b actual %0b", $realtime,
                             want.was_replaced, result.was_replaced);
                end
                if (result.last_voxel !== want.last_voxel)
                begin
                    mismatches++;
                    $display("%0t: last_voxel expected %0b actual %0b", $realtime,
                             want.last_voxel, result.last_voxel);
                end
            end
        end
    end

    // Watchdog: a run that stops moving on every channel is a failure.
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready) || !rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WDOG_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d results outstanding", $realtime,
                     pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        item           = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        result_stall   = 1'b0;
        recv_hold      = 0;
        quiet_cycles   = 0;
        mismatches     = 0;
        words_sent     = 0;
        results_seen   = 0;
        replaced_seen  = 0;
        volumes_done   = 0;
        send_idle_pct  = 21;
        recv_stall_pct = 58;
        in_pos         = 0;
        out_pos        = 0;
        reg_size_x     = SIZE_X_RST;
        reg_size_y     = SIZE_Y_RST;
        reg_size_z     = SIZE_Z_RST;
        reg_cutoff     = CUTOFF_RST;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_size_extremes();
        test_random_volumes(40);
        test_backpressure();

        // Swap the idling sides, then let both run flat out.
        send_idle_pct  = 58;
        recv_stall_pct = 21;
        test_random_volumes(40);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_volumes(40);

        wait_drained();
        $display("Sent %0d words over %0d volumes; checked %0d results, %0d of them filled.",
                 words_sent, volumes_done, results_seen, replaced_seen);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
